// ----- hdl/gtrfb_pkg.sv -----
// ---------------------------------------------------------------------------
// gtrfb_pkg: shared types and constants for the glyph framebuffer
// Command codes, controller/datapath command and status bundles, and the
// 5x7 glyph ROM as a lookup function.
// ---------------------------------------------------------------------------
package gtrfb_pkg;

  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  // two page bytes per glyph column at most
  localparam int DRAW_BYTES = 2 * GLYPH_COLS;

  typedef enum logic [1:0] {
    CMD_FILL = 2'd0,
    CMD_DRAW = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } gtrfb_cmd_e;

  // column c of a glyph, bit r = row r
  typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

  typedef struct packed {
    logic load;       // capture the accepted item
    logic sweep_wr;   // write one byte of a fill or clear sweep
    logic use_fill;   // sweep data is the fill byte, else zero
    logic draw_step;  // read one byte of the cell, queue its write
    logic rd_issue;   // read the byte at the read index
    logic out_load;   // load the result register
  } gtrfb_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic draw_last;
  } gtrfb_sts_t;

  function automatic glyph_t glyph_cols(input logic [6:0] c0, input logic [6:0] c1,
                                        input logic [6:0] c2, input logic [6:0] c3,
                                        input logic [6:0] c4);
    glyph_t g;
    g[0] = c0;
    g[1] = c1;
    g[2] = c2;
    g[3] = c3;
    g[4] = c4;
    return g;
  endfunction

  // unmapped codes fall back to the blank glyph
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    glyph_t g;
    unique case (code)
      8'h2D:   g = glyph_cols(7'h08, 7'h08, 7'h08, 7'h08, 7'h08); // -
      8'h2E:   g = glyph_cols(7'h00, 7'h60, 7'h60, 7'h00, 7'h00); // .
      8'h3A:   g = glyph_cols(7'h00, 7'h36, 7'h36, 7'h00, 7'h00); // :
      8'h30:   g = glyph_cols(7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E);
      8'h31:   g = glyph_cols(7'h00, 7'h42, 7'h7F, 7'h40, 7'h00);
      8'h32:   g = glyph_cols(7'h62, 7'h51, 7'h49, 7'h49, 7'h46);
      8'h33:   g = glyph_cols(7'h22, 7'h49, 7'h49, 7'h49, 7'h36);
      8'h34:   g = glyph_cols(7'h18, 7'h14, 7'h12, 7'h7F, 7'h10);
      8'h35:   g = glyph_cols(7'h2F, 7'h49, 7'h49, 7'h49, 7'h31);
      8'h36:   g = glyph_cols(7'h3E, 7'h49, 7'h49, 7'h49, 7'h32);
      8'h37:   g = glyph_cols(7'h01, 7'h71, 7'h09, 7'h05, 7'h03);
      8'h38:   g = glyph_cols(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
      8'h39:   g = glyph_cols(7'h26, 7'h49, 7'h49, 7'h49, 7'h3E);
      8'h41:   g = glyph_cols(7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E);
      8'h43:   g = glyph_cols(7'h3E, 7'h41, 7'h41, 7'h41, 7'h22);
      8'h45:   g = glyph_cols(7'h7F, 7'h49, 7'h49, 7'h49, 7'h41);
      8'h46:   g = glyph_cols(7'h7F, 7'h09, 7'h09, 7'h09, 7'h01);
      8'h47:   g = glyph_cols(7'h3E, 7'h41, 7'h49, 7'h49, 7'h3A);
      8'h48:   g = glyph_cols(7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F);
      8'h4C:   g = glyph_cols(7'h7F, 7'h40, 7'h40, 7'h40, 7'h40);
      8'h4E:   g = glyph_cols(7'h7F, 7'h06, 7'h18, 7'h60, 7'h7F);
      8'h4F:   g = glyph_cols(7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E);
      8'h52:   g = glyph_cols(7'h7F, 7'h09, 7'h19, 7'h29, 7'h46);
      8'h54:   g = glyph_cols(7'h01, 7'h01, 7'h7F, 7'h01, 7'h01);
      8'h55:   g = glyph_cols(7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F);
      default: g = '0; // space and everything unmapped
    endcase
    return g;
  endfunction

endpackage

// ----- hdl/gtrfb_in_if.sv -----
// ---------------------------------------------------------------------------
// gtrfb_in_if: command channel
// Valid/ready channel carrying one framebuffer command item.
// ---------------------------------------------------------------------------
interface gtrfb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [6:0]  cell_x;
  logic [6:0]  cell_y;
  logic [7:0]  char_code;
  logic [7:0]  fill_byte;
  logic [10:0] read_index;

  modport source (output valid, command, cell_x, cell_y, char_code, fill_byte, read_index,
                  input ready);
  modport sink (input valid, command, cell_x, cell_y, char_code, fill_byte, read_index,
                output ready);
endinterface

// ----- hdl/gtrfb_out_if.sv -----
// ---------------------------------------------------------------------------
// gtrfb_out_if: result channel
// Valid/ready channel carrying one result byte per command.
// ---------------------------------------------------------------------------
interface gtrfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// ----- hdl/gtrfb_dp.sv -----
// ---------------------------------------------------------------------------
// gtrfb_dp: framebuffer datapath
// Item register, framebuffer memory, sweep and cell counters, the
// read-modify-write stage for drawing, and the result register.
// ---------------------------------------------------------------------------
module gtrfb_dp import gtrfb_pkg::*; #(
  parameter int SCREEN_WIDTH  = 96,
  parameter int SCREEN_HEIGHT = 96
) (
  input  logic        clk,
  input  logic        rst_n,
  input  gtrfb_cmd_t  cmd,
  output gtrfb_sts_t  sts,
  input  logic [1:0]  in_command,
  input  logic [6:0]  in_cell_x,
  input  logic [6:0]  in_cell_y,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_fill_byte,
  input  logic [10:0] in_read_index,
  output logic [7:0]  out_read_data
);

  localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_SIZE = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int DCNT_W     = $clog2(DRAW_BYTES);

  // item register
  logic [1:0]  command_r;
  logic [6:0]  cell_x_r;
  logic [6:0]  cell_y_r;
  logic [7:0]  fill_r;
  logic [10:0] ridx_r;
  glyph_t      glyph_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command_r <= in_command;
      cell_x_r  <= in_cell_x;
      cell_y_r  <= in_cell_y;
      fill_r    <= in_fill_byte;
      ridx_r    <= in_read_index;
      glyph_r   <= glyph_lookup(in_char_code);
    end
  end

  // counters
  logic [ADDR_W-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic [DCNT_W-1:0] draw_cnt_r, draw_cnt_nxt;

  assign sts.sweep_last = (32'(sweep_cnt_r) == 32'(STORE_SIZE - 1));
  assign sts.draw_last  = (32'(draw_cnt_r) == 32'(DRAW_BYTES - 1));

  always_comb begin
    sweep_cnt_nxt = sweep_cnt_r;
    draw_cnt_nxt  = draw_cnt_r;
    if (cmd.load) begin
      sweep_cnt_nxt = '0;
      draw_cnt_nxt  = '0;
    end else begin
      if (cmd.sweep_wr) begin
        sweep_cnt_nxt = sts.sweep_last ? '0 : sweep_cnt_r + 1'b1;
      end
      if (cmd.draw_step) begin
        draw_cnt_nxt = sts.draw_last ? '0 : draw_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
      draw_cnt_r  <= '0;
    end else begin
      sweep_cnt_r <= sweep_cnt_nxt;
      draw_cnt_r  <= draw_cnt_nxt;
    end
  end

  // cell byte address and masks: byte k covers glyph column k/2,
  // upper or lower page by k's low bit
  logic [2:0]        col;
  logic              half;
  logic [7:0]        px;
  logic [4:0]        page;
  logic [6:0]        row_ok;
  logic [15:0]       mask16;
  logic [15:0]       data16;
  logic [7:0]        byte_mask;
  logic [7:0]        byte_data;
  logic              byte_ok;
  logic [15:0]       addr_full;
  logic [ADDR_W-1:0] draw_addr;

  assign col  = draw_cnt_r[DCNT_W-1:1];
  assign half = draw_cnt_r[0];
  assign px   = 8'(cell_x_r) + 8'(col);
  assign page = 5'(cell_y_r[6:3]) + 5'(half);

  always_comb begin
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      row_ok[r] = (9'(cell_y_r) + 9'(r)) < 9'(SCREEN_HEIGHT);
    end
  end

  assign mask16    = 16'(row_ok) << cell_y_r[2:0];
  assign data16    = 16'(glyph_r[col]) << cell_y_r[2:0];
  assign byte_mask = half ? mask16[15:8] : mask16[7:0];
  assign byte_data = half ? data16[15:8] : data16[7:0];
  assign byte_ok   = (9'(px) < 9'(SCREEN_WIDTH)) && (byte_mask != 8'h00);
  assign addr_full = 16'(px) + 16'(page) * 16'(SCREEN_WIDTH);
  assign draw_addr = ADDR_W'(addr_full);

  // write stage of the read-modify-write
  logic              s1_vld_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [7:0]        s1_mask_r;
  logic [7:0]        s1_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.draw_step && byte_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_step) begin
      s1_addr_r <= draw_addr;
      s1_mask_r <= byte_mask;
      s1_data_r <= byte_data & byte_mask;
    end
  end

  // framebuffer memory
  logic [7:0]        mem [STORE_SIZE];
  logic [7:0]        q_r;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [ADDR_W-1:0] rd_addr;

  assign mem_we  = cmd.sweep_wr || s1_vld_r;
  assign wr_addr = cmd.sweep_wr ? sweep_cnt_r : s1_addr_r;
  assign wr_data = cmd.sweep_wr ? (cmd.use_fill ? fill_r : 8'h00)
                                : ((q_r & ~s1_mask_r) | s1_data_r);
  assign mem_re  = cmd.draw_step || cmd.rd_issue;
  assign rd_addr = cmd.rd_issue ? ADDR_W'(ridx_r) : draw_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      q_r <= mem[rd_addr];
    end
  end

  // result register
  logic       ridx_ok;
  logic [7:0] read_data_r;

  assign ridx_ok = 32'(ridx_r) < 32'(STORE_SIZE);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_data_r <= (command_r == CMD_READ && ridx_ok) ? q_r : 8'h00;
    end
  end

  assign out_read_data = read_data_r;

`ifndef SYNTH
  a_one_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.sweep_wr && s1_vld_r))
    else $error("sweep write collides with cell write");

  a_draw_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(draw_cnt_r) < 32'(DRAW_BYTES))
    else $error("cell byte counter out of range");
`endif

endmodule

// ----- hdl/gtrfb_ctrl.sv -----
// ---------------------------------------------------------------------------
// gtrfb_ctrl: command sequencer
// Clears the store after reset, then takes one command at a time and steps
// the datapath through its fill sweep, cell update or byte read.
// ---------------------------------------------------------------------------
module gtrfb_ctrl import gtrfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output gtrfb_cmd_t cmd,
  input  gtrfb_sts_t sts
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_FILL   = 6'b000100,
    ST_DRAW   = 6'b001000,
    ST_READ   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_command)
            CMD_FILL: state_nxt = ST_FILL;
            CMD_DRAW: state_nxt = ST_DRAW;
            CMD_READ: state_nxt = ST_READ;
            default:  state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_FILL: begin
        cmd.sweep_wr = 1'b1;
        cmd.use_fill = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_DRAW: begin
        cmd.draw_step = 1'b1;
        if (sts.draw_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_finish_posts_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && slot_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished command did not post its result");

  a_single_memory_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.sweep_wr && (cmd.draw_step || cmd.rd_issue || cmd.load)))
    else $error("sweep overlaps another memory operation");
`endif

endmodule

// ----- hdl/glyph_text_renderer_page_framebuffer_top.sv -----
// ---------------------------------------------------------------------------
// glyph_text_renderer_page_framebuffer_top: 5x7 text renderer and framebuffer
// Page-organized monochrome framebuffer with fill, draw-character and
// byte-read commands over valid/ready channels.
// ---------------------------------------------------------------------------
// The store holds SCREEN_WIDTH columns by ceil(SCREEN_HEIGHT/8) pages; each
// byte carries 8 vertical pixels, bit (row mod 8) at address
// column + page * SCREEN_WIDTH. Every command returns exactly one result
// transfer: the stored byte for a read (zero when the index is past the
// store), zero for fill, draw and the unused code. Commands run one at a
// time through a single-write, single-read framebuffer memory. After reset
// the store is swept to zero, one byte a cycle, across all SCREEN_WIDTH *
// pages bytes (1152 at 96 x 96) before the first command is taken. A fill
// writes one byte per cycle across the store; a draw covers ten page bytes,
// each read and then written back in the cycle after its read, so reads and
// writes overlap; a read goes through the registered memory read; the unused
// code goes straight to its result. Unknown character codes draw the blank
// glyph; pixels off the right or bottom edge are left untouched.
// ---------------------------------------------------------------------------
module glyph_text_renderer_page_framebuffer_top import gtrfb_pkg::*; #(
  parameter int SCREEN_WIDTH  = 96,
  parameter int SCREEN_HEIGHT = 96
) (
  input logic              clk,
  input logic              rst_n,
  gtrfb_in_if.sink         in_ch,
  gtrfb_out_if.source      out_ch
);

  gtrfb_cmd_t cmd;
  gtrfb_sts_t sts;

  // sequencer: owns both handshakes and steps the datapath
  gtrfb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // datapath: item capture, framebuffer memory, result byte
  gtrfb_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_command    (in_ch.command),
    .in_cell_x     (in_ch.cell_x),
    .in_cell_y     (in_ch.cell_y),
    .in_char_code  (in_ch.char_code),
    .in_fill_byte  (in_ch.fill_byte),
    .in_read_index (in_ch.read_index),
    .out_read_data (out_ch.read_data)
  );

endmodule

// ----- sim/glyph_text_renderer_page_framebuffer_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// glyph_text_renderer_page_framebuffer_top_tb: framebuffer and text renderer
// Drives fill, draw-character, read and unused commands through the command
// channel and checks every result byte against a fixed value or a cycle-free
// shadow of the page-organized store, kept in step with each accepted transfer.
// ---------------------------------------------------------------------------
module glyph_text_renderer_page_framebuffer_top_tb;
  import gtrfb_pkg::*;

  localparam int SCREEN_W     = 96;
  localparam int SCREEN_H     = 96;
  localparam int PAGES        = (SCREEN_H + 7) / 8;
  localparam int STORE_BYTES  = SCREEN_W * PAGES;
  localparam int RANDOM_ITEMS = 850;
  localparam int REPORT_LIMIT = 10;
  // every mapped character plus the space, one byte each
  localparam logic [8*26-1:0] GLYPH_SET = " -.:0123456789ACEFGHLNORTU";

  typedef struct {
    gtrfb_cmd_e  op;
    logic [6:0]  col;
    logic [6:0]  row;
    logic [7:0]  code;
    logic [7:0]  fill;
    logic [10:0] index;
  } fb_cmd_t;

  // one line of the directed table; want is used only when typed is set
  typedef struct {
    fb_cmd_t    cmd;
    bit         typed;
    logic [7:0] want;
  } plan_row_t;

  // receiver back-pressure styles
  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_CHOPPY,
    DRAIN_PERIODIC,
    DRAIN_HEAVY
  } drain_style_e;

  logic clk = 1'b0;
  logic rst_n;

  gtrfb_in_if  in_ch ();
  gtrfb_out_if out_ch ();

  glyph_text_renderer_page_framebuffer_top #(
    .SCREEN_WIDTH  (SCREEN_W),
    .SCREEN_HEIGHT (SCREEN_H)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 2 ns period
  always #1 clk = ~clk;

  // Shadow of the framebuffer and the result bytes still owed by the block.
  logic [7:0]  frame_copy [STORE_BYTES];
  logic [7:0]  expected_read_data [$];
  plan_row_t   directed_plan [$];

  int burst_left;
  int fill_count, draw_count, read_count, unused_count;
  int results_checked;
  int mismatch_count;
  int fail_count;

  // -------------------------------------------------------------------------
  // Glyph shapes: five column bytes, leftmost column in the top byte. Bit r
  // of a column lights row r of the cell. Anything not listed is blank.
  // -------------------------------------------------------------------------
  function automatic logic [39:0] glyph_shape(input logic [7:0] code);
    case (code)
      "-":     return 40'h08_08_08_08_08;
      ".":     return 40'h00_60_60_00_00;
      ":":     return 40'h00_36_36_00_00;
      "0":     return 40'h3E_51_49_45_3E;
      "1":     return 40'h00_42_7F_40_00;
      "2":     return 40'h62_51_49_49_46;
      "3":     return 40'h22_49_49_49_36;
      "4":     return 40'h18_14_12_7F_10;
      "5":     return 40'h2F_49_49_49_31;
      "6":     return 40'h3E_49_49_49_32;
      "7":     return 40'h01_71_09_05_03;
      "8":     return 40'h36_49_49_49_36;
      "9":     return 40'h26_49_49_49_3E;
      "A":     return 40'h7E_11_11_11_7E;
      "C":     return 40'h3E_41_41_41_22;
      "E":     return 40'h7F_49_49_49_41;
      "F":     return 40'h7F_09_09_09_01;
      "G":     return 40'h3E_41_49_49_3A;
      "H":     return 40'h7F_08_08_08_7F;
      "L":     return 40'h7F_40_40_40_40;
      "N":     return 40'h7F_06_18_60_7F;
      "O":     return 40'h3E_41_41_41_3E;
      "R":     return 40'h7F_09_19_29_46;
      "T":     return 40'h01_01_7F_01_01;
      "U":     return 40'h3F_40_40_40_3F;
      default: return 40'h0;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Apply one command to the shadow store and return the byte the block
  // must send back for it.
  // -------------------------------------------------------------------------
  function automatic logic [7:0] apply_command(input fb_cmd_t c);
    logic [39:0] shape;
    logic [7:0]  column_bits;
    logic [7:0]  data;
    int          gc, gr, px, py;
    data = 8'h00;
    case (c.op)
      CMD_FILL: begin
        // fill writes whole bytes, unused rows of a last page included
        foreach (frame_copy[i]) frame_copy[i] = c.fill;
      end
      CMD_DRAW: begin
        shape = glyph_shape(c.code);
        for (gc = 0; gc < GLYPH_COLS; gc++) begin
          column_bits = shape[39 - 8 * gc -: 8];
          for (gr = 0; gr < GLYPH_ROWS; gr++) begin
            px = c.col + gc;
            py = c.row + gr;
            // skip pixels past the right or bottom edge, never wrap
            if (px < SCREEN_W && py < SCREEN_H) begin
              frame_copy[px + (py / 8) * SCREEN_W][py % 8] = column_bits[gr];
            end
          end
        end
      end
      CMD_READ: begin
        // reads past the store return zero
        if (c.index < STORE_BYTES) data = frame_copy[c.index];
      end
      default: ;
    endcase
    return data;
  endfunction

  function automatic fb_cmd_t make_cmd(input gtrfb_cmd_e op, input int x, input int y,
                                       input int code, input int fill, input int idx);
    fb_cmd_t c;
    c.op    = op;
    c.col   = 7'(x);
    c.row   = 7'(y);
    c.code  = 8'(code);
    c.fill  = 8'(fill);
    c.index = 11'(idx);
    return c;
  endfunction

  // Random content in every field; the caller overrides what matters.
  function automatic fb_cmd_t random_cmd(input gtrfb_cmd_e op);
    return make_cmd(op, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 2047));
  endfunction

  function automatic plan_row_t plan(input gtrfb_cmd_e op, input int x, input int y,
                                     input int code, input int fill, input int idx,
                                     input bit typed, input logic [7:0] want);
    plan_row_t r;
    r.cmd   = make_cmd(op, x, y, code, fill, idx);
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Send one command. Hold valid and the payload until the transfer, then
  // record the expected result. Between bursts drop valid for a random gap;
  // inside a burst the next call raises valid again with a single update.
  // -------------------------------------------------------------------------
  task automatic issue(input fb_cmd_t c, input bit typed, input logic [7:0] want);
    logic [7:0] predicted;
    in_ch.valid      <= 1'b1;
    in_ch.command    <= c.op;
    in_ch.cell_x     <= c.col;
    in_ch.cell_y     <= c.row;
    in_ch.char_code  <= c.code;
    in_ch.fill_byte  <= c.fill;
    in_ch.read_index <= c.index;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = apply_command(c);
    expected_read_data.push_back(typed ? want : predicted);
    case (c.op)
      CMD_FILL: fill_count++;
      CMD_DRAW: draw_count++;
      CMD_READ: read_count++;
      default:  unused_count++;
    endcase
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      // mostly short bursts, now and then a long unbroken stretch
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
  endtask

  // Hold off new commands until every owed result has come back. With
  // nothing owed valid is already low and is left alone.
  task automatic settle(input int max_cycles);
    int waited;
    waited = 0;
    if (expected_read_data.size() != 0) in_ch.valid <= 1'b0;
    while (expected_read_data.size() != 0 && waited < max_cycles) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // -------------------------------------------------------------------------
  // Receiver: ready follows a style re-picked at random periodically: always
  // ready, choppy, periodic stalls or heavy back-pressure.
  // -------------------------------------------------------------------------
  initial begin : receiver
    drain_style_e style;
    int unsigned  tick;
    style = DRAIN_FREE;
    tick  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 64 == 0) style = drain_style_e'($urandom_range(0, 3));
      case (style)
        DRAIN_FREE:     out_ch.ready <= 1'b1;
        DRAIN_CHOPPY:   out_ch.ready <= ($urandom_range(0, 3) != 0);
        DRAIN_PERIODIC: out_ch.ready <= (tick % 16 >= 12);
        default:        out_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Result checker: compare every result transfer with the oldest owed byte.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    logic [7:0] want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_read_data.size() == 0) begin
        mismatch_count++;
        fail_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected result, read_data %02h with nothing owed",
                   $realtime, out_ch.read_data);
      end else begin
        want = expected_read_data.pop_front();
        results_checked++;
        if (out_ch.read_data !== want) begin
          mismatch_count++;
          fail_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result %0d read_data expected %02h got %02h",
                     $realtime, results_checked, want, out_ch.read_data);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence: reset, directed table, random scenes, drain, verdict.
  // -------------------------------------------------------------------------
  initial begin : stimulus
    fb_cmd_t c;
    int      x, y, count, k, p, pick, random_sent, directed_total;
    bit      paused_mid_run;

    foreach (frame_copy[i]) frame_copy[i] = 8'h00;
    fill_count = 0;
    draw_count = 0;
    read_count = 0;
    unused_count = 0;
    results_checked = 0;
    mismatch_count = 0;
    fail_count = 0;
    paused_mid_run = 1'b0;

    // Hold every input at a known value through reset.
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_NOP;
    in_ch.cell_x     <= '0;
    in_ch.cell_y     <= '0;
    in_ch.char_code  <= '0;
    in_ch.fill_byte  <= '0;
    in_ch.read_index <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    burst_left = $urandom_range(1, 12);

    // Directed table. Typed results: cleared store after reset, whole-store
    // fills, reads past the store and every non-read command return values
    // known up front; the rest go through the shadow store.
    directed_plan.push_back(plan(CMD_READ, 0, 0, 0, 0, 0, 1'b1, 8'h00));
    directed_plan.push_back(plan(CMD_READ, 0, 0, 0, 0, STORE_BYTES - 1, 1'b1, 8'h00));
    // index with every bit set, well past the store
    directed_plan.push_back(plan(CMD_READ, 0, 0, 0, 0, 2047, 1'b1, 8'h00));
    // unused code with every field at its top value must change nothing
    directed_plan.push_back(plan(CMD_NOP, 127, 127, 255, 255, 2047, 1'b1, 8'h00));
    directed_plan.push_back(plan(CMD_FILL, 0, 0, 0, 8'hFF, 0, 1'b1, 8'h00));
    directed_plan.push_back(plan(CMD_READ, 0, 0, 0, 0, 0, 1'b1, 8'hFF));
    directed_plan.push_back(plan(CMD_READ, 0, 0, 0, 0, STORE_BYTES - 1, 1'b1, 8'hFF));
    directed_plan.push_back(plan(CMD_READ, 0, 0, 0, 0, STORE_BYTES, 1'b1, 8'h00));
    // glyph over a full background: bit 7 of page 0 must survive
    directed_plan.push_back(plan(CMD_DRAW, 0, 0, "8", 0, 0, 1'b1, 8'h00));
    directed_plan.push_back(plan(CMD_READ, 0, 0, 0, 0, 0, 1'b0, 8'h00));
    directed_plan.push_back(plan(CMD_READ, 0, 0, 0, 0, 4, 1'b0, 8'h00));
    // bottom-right corner: the last row of the cell falls off the screen
    directed_plan.push_back(plan(CMD_DRAW, 91, 90, "N", 0, 0, 1'b1, 8'h00));
    directed_plan.push_back(plan(CMD_READ, 0, 0, 0, 0, 91 + 11 * SCREEN_W, 1'b0, 8'h00));
    directed_plan.push_back(plan(CMD_READ, 0, 0, 0, 0, STORE_BYTES - 1, 1'b0, 8'h00));
    // right edge clip with a cell that straddles two pages
    directed_plan.push_back(plan(CMD_DRAW, 94, 3, "U", 0, 0, 1'b1, 8'h00));
    directed_plan.push_back(plan(CMD_READ, 0, 0, 0, 0, 95, 1'b0, 8'h00));
    directed_plan.push_back(plan(CMD_READ, 0, 0, 0, 0, 95 + SCREEN_W, 1'b0, 8'h00));
    // unmapped code draws blank and clears the cell
    directed_plan.push_back(plan(CMD_DRAW, 0, 0, 8'hFF, 0, 0, 1'b1, 8'h00));
    directed_plan.push_back(plan(CMD_READ, 0, 0, 0, 0, 0, 1'b0, 8'h00));
    // whole cell off screen
    directed_plan.push_back(plan(CMD_DRAW, 127, 127, " ", 0, 0, 1'b1, 8'h00));
    directed_plan.push_back(plan(CMD_FILL, 0, 0, 0, 8'h00, 0, 1'b1, 8'h00));
    directed_plan.push_back(plan(CMD_DRAW, 10, 13, "A", 0, 0, 1'b1, 8'h00));
    directed_plan.push_back(plan(CMD_READ, 0, 0, 0, 0, 10 + SCREEN_W, 1'b0, 8'h00));
    directed_plan.push_back(plan(CMD_READ, 0, 0, 0, 0, 14 + 2 * SCREEN_W, 1'b0, 8'h00));
    directed_plan.push_back(plan(CMD_DRAW, 0, 0, 8'h00, 0, 0, 1'b1, 8'h00));

    foreach (directed_plan[i])
      issue(directed_plan[i].cmd, directed_plan[i].typed, directed_plan[i].want);
    directed_total = directed_plan.size();

    // Pause the sender until the directed results are all back.
    settle(20000);

    // Random part: mostly scenes of one to three characters written side by
    // side and then read back page by page, plus noise commands.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        issue(random_cmd(CMD_FILL), 1'b0, 8'h00);
      end else if (pick < 8) begin
        issue(random_cmd(CMD_NOP), 1'b0, 8'h00);
      end else if (pick < 16) begin
        c = random_cmd(CMD_READ);
        if ($urandom_range(0, 1) == 0) c.index = 11'($urandom_range(0, STORE_BYTES - 1));
        issue(c, 1'b0, 8'h00);
      end else begin
        x = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 95);
        y = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 95);
        count = $urandom_range(1, 3);
        for (k = 0; k < count && x + 6 * k <= 127; k++) begin
          c = random_cmd(CMD_DRAW);
          c.col = 7'(x + 6 * k);
          c.row = 7'(y);
          if ($urandom_range(0, 4) != 0) c.code = GLYPH_SET[8 * $urandom_range(0, 25) +: 8];
          issue(c, 1'b0, 8'h00);
        end
        // read back about half of the bytes the scene touched
        for (k = 0; k < 6 * count; k++) begin
          for (p = y / 8; p <= (y + 6) / 8; p++) begin
            if ($urandom_range(0, 1) == 0) begin
              c = random_cmd(CMD_READ);
              c.index = 11'(x + k + p * SCREEN_W);
              issue(c, 1'b0, 8'h00);
            end
          end
        end
      end
      random_sent = fill_count + draw_count + read_count + unused_count - directed_total;
      // Drain once in the middle of the run with the sender quiet.
      if (!paused_mid_run && random_sent >= RANDOM_ITEMS / 2) begin
        paused_mid_run = 1'b1;
        settle(20000);
      end
    end

    // Wait for the last results, then give a stray result time to show up.
    settle(20000);
    repeat (32) @(posedge clk);
    fail_count += expected_read_data.size();

    $display("covered %0d commands: %0d fill, %0d draw, %0d read, %0d unused code",
             fill_count + draw_count + read_count + unused_count,
             fill_count, draw_count, read_count, unused_count);
    $display("%0d result bytes checked, %0d mismatched, %0d still owed",
             results_checked, mismatch_count, expected_read_data.size());
    if (fail_count == 0) begin
      $display("glyph_text_renderer_page_framebuffer_top regression: pass");
    end else begin
      $display("glyph_text_renderer_page_framebuffer_top regression: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #4_000_000;
    $display("glyph_text_renderer_page_framebuffer_top regression: fail");
    $finish;
  end

endmodule
